[rtl/mwet_pkg.sv]
`default_nettype none

package mwet_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int IN_W           = 32;
    localparam int CNT_W          = 16;
    localparam int INT_BITS       = 6;
    localparam int RING_DEPTH     = 7;
    localparam int TAG_W          = $clog2(RING_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(256);

    typedef struct packed {
        logic             valid;
        logic             done;
        logic             escaped;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } ctl_t;

endpackage

`default_nettype wire

[rtl/manowar_escape_time.sv]
// Escape-time test for the Manowar map z' = z*z + z_prev + c, with z and z_prev
// starting at c, on signed Q6.F fixed point (F = DATA_WIDTH - 6) with saturating
// arithmetic. Each input transaction carries one point c in Q6.26 and gives one
// result transaction: the iterations done and whether |z|^2 exceeded 4. One
// iteration is a pass through a 7-stage ring pipeline (magnitude, partial
// products, product sum, truncate/saturate, square-difference and escape compare,
// two accumulate stages). The iteration limit resets to 256. Up to 7 points
// share the ring, one per slot; a new point enters whenever the slot at the ring
// head is free. Results leave in input order: a finished point keeps circulating
// until it is the oldest one in flight. The user must write max_iterations
// through the cfg channel (always ready) only while no point is in flight;
// the block itself does not enforce this.
`default_nettype none

module manowar_escape_time #(
    parameter int DATA_WIDTH = mwet_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mwet_pkg::CNT_W-1:0]      cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [mwet_pkg::IN_W-1:0] s_c_real,
    input  wire logic signed [mwet_pkg::IN_W-1:0] s_c_imag,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mwet_pkg::CNT_W-1:0]           m_iteration_count,
    output logic                                 m_escaped
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = W - mwet_pkg::INT_BITS;
    localparam int HL = W / 2;
    localparam int HU = W - HL;
    localparam int PW = 2 * W;
    localparam int QW = PW - F;
    localparam int TW = mwet_pkg::TAG_W;
    localparam int CW = mwet_pkg::CNT_W;

    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] FOUR = {{(mwet_pkg::INT_BITS-3){1'b0}}, 3'b100, {F{1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] zr;
        logic signed [W-1:0] zi;
        logic signed [W-1:0] pr;
        logic signed [W-1:0] pi;
        logic signed [W-1:0] cr;
        logic signed [W-1:0] ci;
    } pt_t;

    typedef struct packed {
        logic [2*HU-1:0]  hh;
        logic [HL+HU-1:0] hl;
        logic [HL+HU-1:0] lh;
        logic [2*HL-1:0]  ll;
    } pp_t;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        logic [W-1:0] u;
        u = a;
        return a[W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic pp_t pmul(input logic [W-1:0] a, input logic [W-1:0] b);
        pp_t p;
        p.hh = a[W-1:HL] * b[W-1:HL];
        p.hl = a[W-1:HL] * b[HL-1:0];
        p.lh = a[HL-1:0] * b[W-1:HL];
        p.ll = a[HL-1:0] * b[HL-1:0];
        return p;
    endfunction

    function automatic logic [PW-1:0] psum(input pp_t p);
        return (PW'(p.hh) << (2 * HL)) + (PW'(p.hl) << HL) + (PW'(p.lh) << HL)
               + PW'(p.ll);
    endfunction

    // magnitude truncated toward zero, then saturated and signed
    function automatic logic signed [W-1:0] pfix(input logic [PW-1:0] m,
                                                 input logic neg);
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        logic [W-1:0]  ql;
        q   = m[PW-1:F];
        lim = QW'(VMAX) + QW'(neg);
        if (q > lim) begin
            q = lim;
        end
        ql = q[W-1:0];
        return neg ? $signed(-ql) : $signed(ql);
    endfunction

    logic [CW-1:0] max_iter_reg;
    logic [TW-1:0] in_tag_reg;
    logic [TW-1:0] head_tag_reg;

    mwet_pkg::ctl_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    pt_t            p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    mwet_pkg::ctl_t c0_next;
    pt_t            p0_next;

    logic [W-1:0]        mr_reg, mi_reg;
    logic                nri1_reg, nri2_reg, nri3_reg;
    pp_t                 pp_rr_reg, pp_ii_reg, pp_ri_reg;
    logic [PW-1:0]       m_rr_reg, m_ii_reg, m_ri_reg;
    logic signed [W-1:0] rr_reg, ii_reg, ri_reg;
    logic                esc5_reg, esc6_reg;
    logic signed [W-1:0] re1_reg, im1_reg, re2_reg, im2_reg;

    logic                m_valid_reg;
    logic [CW-1:0]       m_count_reg;
    logic                m_esc_reg;

    logic signed [W-1:0] cr_in, ci_in;
    logic signed [W-1:0] re3, im3;
    logic [W:0]          mag2;
    mwet_pkg::ctl_t      fin;
    pt_t                 fin_p;
    logic                retire;
    logic                slot_free;
    logic [TW-1:0]       occ;

    generate
        if (W >= mwet_pkg::IN_W) begin : g_up
            assign cr_in = W'(s_c_real) <<< (W - mwet_pkg::IN_W);
            assign ci_in = W'(s_c_imag) <<< (W - mwet_pkg::IN_W);
        end else begin : g_dn
            assign cr_in = W'(s_c_real >>> (mwet_pkg::IN_W - W));
            assign ci_in = W'(s_c_imag >>> (mwet_pkg::IN_W - W));
        end
    endgenerate

    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_escaped         = m_esc_reg;
    assign s_ready           = slot_free;
    assign mag2              = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign occ               = in_tag_reg - head_tag_reg;

    always_comb begin
        re3   = sat_add(re2_reg, p6_reg.cr);
        im3   = sat_add(im2_reg, p6_reg.ci);
        fin   = c6_reg;
        fin_p = p6_reg;
        if (c6_reg.valid && !c6_reg.done) begin
            if (c6_reg.count >= max_iter_reg) begin
                fin.done = 1'b1;
            end else if (esc6_reg) begin
                fin.done    = 1'b1;
                fin.escaped = 1'b1;
            end else begin
                fin_p.zr  = re3;
                fin_p.zi  = im3;
                fin_p.pr  = p6_reg.zr;
                fin_p.pi  = p6_reg.zi;
                fin.count = c6_reg.count + 1'b1;
            end
        end
        retire    = fin.valid && fin.done && (fin.tag == head_tag_reg)
                    && (!m_valid_reg || m_ready);
        slot_free = !fin.valid || retire;
        c0_next   = fin;
        p0_next   = fin_p;
        if (retire) begin
            c0_next.valid = 1'b0;
        end
        if (s_valid && slot_free) begin
            c0_next.valid   = 1'b1;
            c0_next.done    = 1'b0;
            c0_next.escaped = 1'b0;
            c0_next.tag     = in_tag_reg;
            c0_next.count   = '0;
            p0_next.zr      = cr_in;
            p0_next.zi      = ci_in;
            p0_next.pr      = cr_in;
            p0_next.pi      = ci_in;
            p0_next.cr      = cr_in;
            p0_next.ci      = ci_in;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= mwet_pkg::MAX_ITER_RST;
            in_tag_reg   <= '0;
            head_tag_reg <= '0;
            c0_reg       <= '0;
            c1_reg       <= '0;
            c2_reg       <= '0;
            c3_reg       <= '0;
            c4_reg       <= '0;
            c5_reg       <= '0;
            c6_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_iter_reg <= cfg_data;
            end
            if (s_valid && slot_free) begin
                in_tag_reg <= in_tag_reg + 1'b1;
            end
            if (retire) begin
                head_tag_reg <= head_tag_reg + 1'b1;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            c0_reg <= c0_next;
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (retire) begin
            m_count_reg <= fin.count;
            m_esc_reg   <= fin.escaped;
        end
        p0_reg    <= p0_next;
        p1_reg    <= p0_reg;
        mr_reg    <= mag(p0_reg.zr);
        mi_reg    <= mag(p0_reg.zi);
        nri1_reg  <= p0_reg.zr[W-1] ^ p0_reg.zi[W-1];
        p2_reg    <= p1_reg;
        pp_rr_reg <= pmul(mr_reg, mr_reg);
        pp_ii_reg <= pmul(mi_reg, mi_reg);
        pp_ri_reg <= pmul(mr_reg, mi_reg);
        nri2_reg  <= nri1_reg;
        p3_reg    <= p2_reg;
        m_rr_reg  <= psum(pp_rr_reg);
        m_ii_reg  <= psum(pp_ii_reg);
        m_ri_reg  <= psum(pp_ri_reg);
        nri3_reg  <= nri2_reg;
        p4_reg    <= p3_reg;
        rr_reg    <= pfix(m_rr_reg, 1'b0);
        ii_reg    <= pfix(m_ii_reg, 1'b0);
        ri_reg    <= pfix(m_ri_reg, nri3_reg);
        p5_reg    <= p4_reg;
        esc5_reg  <= mag2 > {1'b0, FOUR};
        re1_reg   <= sat_sub(rr_reg, ii_reg);
        im1_reg   <= sat_add(ri_reg, ri_reg);
        p6_reg    <= p5_reg;
        esc6_reg  <= esc5_reg;
        re2_reg   <= sat_add(re1_reg, p5_reg.pr);
        im2_reg   <= sat_add(im1_reg, p5_reg.pi);
    end

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({c0_reg.valid, c1_reg.valid, c2_reg.valid, c3_reg.valid,
                    c4_reg.valid, c5_reg.valid, c6_reg.valid}) == int'(occ))
        else $error("ring occupancy disagrees with tag counters");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        c0_reg.valid |-> c0_reg.count <= max_iter_reg)
        else $error("iteration count passed the limit");

    a_esc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        c0_reg.valid && c0_reg.escaped |-> c0_reg.done)
        else $error("escaped slot not marked done");

    a_esc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_esc_reg |-> m_count_reg < max_iter_reg)
        else $error("escape reported at the limit");

    a_inside_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_esc_reg |-> m_count_reg == max_iter_reg)
        else $error("non-escaped point stopped before the limit");

endmodule

`default_nettype wire
